// ===== rtl/core/dkd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkd_pkg
// Shared widths, reset values and register indexes of the door knock event
// detector.
// ----------------------------------------------------------------------------
package dkd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;

  localparam int unsigned Z_W     = 14;
  localparam int unsigned DELTA_W = 15;
  localparam int unsigned THR_W   = 14;
  localparam int unsigned TRIG_W  = 5;
  localparam int unsigned TIME_W  = 32;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [THR_W-1:0]  THR_RESET  = 14'd512;
  localparam logic [TRIG_W-1:0] TRIG_RESET = 5'd3;

  localparam logic REG_DELTA_THRESHOLD = 1'b0;
  localparam logic REG_TRIGGER_COUNT   = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/dkd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dkd_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module dkd_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/door_knock_event_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// door_knock_event_detector
// Counts large Z-axis jolts in a window of recent sample differences and
// flags a door opening when enough of them are present.
// ----------------------------------------------------------------------------
// Each accepted beat writes its Z difference into the window RAM, then the
// block reads all WINDOW_DEPTH entries through the single RAM read port,
// one per cycle, and counts those at or above the threshold. No new beat
// is taken until the walk, the tail state and the done state have passed;
// the result sits in an output register until it is taken. Clearing the
// window after an opening is immediate through per-entry valid bits, so
// there is no clearing pass after reset.
module door_knock_event_detector #(
  parameter int unsigned WINDOW_DEPTH = dkd_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [dkd_pkg::Z_W-1:0]       in_z_sample,
  input  wire logic        [dkd_pkg::TIME_W-1:0]    in_now_ms,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic             [dkd_pkg::TIME_W-1:0]    out_elapsed_ms,
  output logic                                      out_opened,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic        [dkd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic        [dkd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic             [dkd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                      cfg_pready
);

  import dkd_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > TRIG_W) ? CNT_W : TRIG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [THR_W-1:0]        thr_r;
  logic [TRIG_W-1:0]       trig_r;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [Z_W-1:0]   prev_z_r;
  logic [TIME_W-1:0]       last_open_r;
  logic [TIME_W-1:0]       now_r;
  logic [WINDOW_DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]        rd_addr_r, rd_addr_nxt;
  logic                    pend_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0]       out_elapsed_r;
  logic                    out_opened_r;

  logic                    in_acc;
  logic                    cfg_wr;
  logic [DELTA_W-1:0]      diff;
  logic [DELTA_W-1:0]      ram_rdata;
  logic [DELTA_W-1:0]      rd_val;
  logic [DELTA_W-1:0]      mag;
  logic                    hit;
  logic                    trig_hit;
  logic                    commit;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign diff = {in_z_sample[Z_W-1], in_z_sample} - {prev_z_r[Z_W-1], prev_z_r};

  dkd_ram #(
    .WIDTH (DELTA_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (pos_r),
    .wdata (diff),
    .re    (state_r == S_WALK),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign rd_val   = valid_r[pend_idx_r] ? ram_rdata : '0;
  assign mag      = rd_val[DELTA_W-1] ? (DELTA_W'(0) - rd_val) : rd_val;
  assign hit      = (mag >= {1'b0, thr_r});
  assign trig_hit = (CMP_W'(cnt_r) >= CMP_W'(trig_r));
  assign commit   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rd_addr_nxt   = rd_addr_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_r && hit) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt     = '0;
        rd_addr_nxt = '0;
        if (in_acc) begin
          valid_nxt[pos_r] = 1'b1;
          pos_nxt          = (pos_r == LAST_IDX) ? '0 : pos_r + IDX_W'(1);
          state_nxt        = S_WALK;
        end
      end
      S_WALK: begin
        if (rd_addr_r == LAST_IDX) begin
          state_nxt = S_TAIL;
        end else begin
          rd_addr_nxt = rd_addr_r + IDX_W'(1);
        end
      end
      S_TAIL: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (trig_hit) begin
            valid_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= THR_RESET;
      trig_r      <= TRIG_RESET;
      pos_r       <= '0;
      prev_z_r    <= '0;
      last_open_r <= '0;
      valid_r     <= '0;
      rd_addr_r   <= '0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      valid_r     <= valid_nxt;
      rd_addr_r   <= rd_addr_nxt;
      pend_r      <= (state_r == S_WALK);
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        prev_z_r <= in_z_sample;
      end
      if (commit && trig_hit) begin
        last_open_r <= now_r;
      end
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_DELTA_THRESHOLD: thr_r  <= cfg_pwdata[THR_W-1:0];
          REG_TRIGGER_COUNT:   trig_r <= cfg_pwdata[TRIG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= rd_addr_r;
    if (in_acc) begin
      now_r <= in_now_ms;
    end
    if (commit) begin
      out_opened_r  <= trig_hit;
      out_elapsed_r <= trig_hit ? '0 : (now_r - last_open_r);
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_DELTA_THRESHOLD: cfg_prdata = CFG_DATA_W'(thr_r);
      REG_TRIGGER_COUNT:   cfg_prdata = CFG_DATA_W'(trig_r);
      default:             cfg_prdata = '0;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_elapsed_ms = out_elapsed_r;
  assign out_opened     = out_opened_r;

endmodule

`default_nettype wire
